FILE: rtl/r184_pkg.sv
// Shared constants, types and helpers for the Rule 184 traffic ring.
`timescale 1ns / 1ps
`default_nettype none
package r184_pkg;

  localparam int MAX_CELLS = 1024;
  localparam int MIN_LEN   = 3;
  localparam int IDX_W     = $clog2(MAX_CELLS);
  localparam int CNT_W     = $clog2(MAX_CELLS + 1);
  localparam int LEN_W     = 11;
  localparam int FRAC_BITS = 16;
  localparam int QUOT_W    = FRAC_BITS + 1;

  // Popcount tree shape: groups of GRP_BITS cells, then SUM_FAN groups per
  // second-level sum, then one final sum over SUM_CNT values.
  localparam int GRP_BITS = 16;
  localparam int GRP_CNT  = MAX_CELLS / GRP_BITS;
  localparam int GRP_W    = $clog2(GRP_BITS + 1);
  localparam int SUM_FAN  = 8;
  localparam int SUM_CNT  = GRP_CNT / SUM_FAN;
  localparam int SUM_W    = $clog2(GRP_BITS * SUM_FAN + 1);

  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 1 + CNT_W + CNT_W + QUOT_W;

  localparam logic [1:0] MODE_LOAD = 2'd0;
  localparam logic [1:0] MODE_STEP = 2'd1;
  localparam logic [1:0] MODE_READ = 2'd2;

  typedef struct packed {
    logic step;
    logic cfg_wr;
  } cell_ctrl_t;

  typedef struct packed {
    logic [QUOT_W-1:0] velocity_q16;
    logic [CNT_W-1:0]  car_total;
    logic [CNT_W-1:0]  departed_count;
    logic              read_value;
  } out_item_t;

  // Saturates a written road length to the supported ring sizes.
  function automatic logic [CNT_W-1:0] clamp_len(input logic [LEN_W-1:0] len);
    int v;
    v = int'(len);
    if (v < MIN_LEN) v = MIN_LEN;
    if (v > MAX_CELLS) v = MAX_CELLS;
    return CNT_W'(v);
  endfunction

endpackage
`default_nettype wire

FILE: rtl/rule184_traffic_ring_step_top.sv
// Top level of the Rule 184 traffic ring: cell row, counter, divider, output queue.
//
//  Channel    Direction  Handshake                   Payload
//  s_axis     in         tvalid / tready             mode, cell_index, cell_value
//  m_axis     out        tvalid / tready             read_value, departed_count,
//                                                    car_total, velocity_q16
//  cfg        in         cfg_we_i (no wait)          road_length
//
// Load, read and unused-mode requests complete at acceptance; their result is in
// the output queue the cycle after acceptance.
// A step request updates the cells at acceptance and its result reaches the queue
// after the popcount tree stages, the divider load, bit-by-bit division and the
// hand-over of the result. The input is held off until then.
// After reset and after every length write, a recount of the cars
// holds the input off. A two-entry output queue lets new requests enter
// while results wait; apart from a step or a recount in progress, the input
// stalls only when both entries are full.
`timescale 1ns / 1ps
`default_nettype none
module rule184_traffic_ring_step_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [r184_pkg::LEN_W-1:0]       cfg_wdata_i,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [1:0] mode, [11:2] cell_index, [12] cell_value, [15:13] zero
  input  logic [r184_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [0] read_value, [11:1] departed_count, [22:12] car_total, [39:23] velocity_q16
  output logic [r184_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);
  import r184_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE    = 4'b0001,
    ST_COUNT   = 4'b0010,
    ST_DIV     = 4'b0100,
    ST_RECOUNT = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [CNT_W-1:0] n_q;
  logic [CNT_W-1:0] n_new;
  logic [CNT_W-1:0] tally_q, tally_d;
  logic [CNT_W-1:0] moved_q;
  logic             go_q;

  logic [1:0]       in_mode;
  logic [IDX_W-1:0] in_idx;
  logic             in_val;
  logic             accept;
  logic             load_go;
  logic             step_go;

  cell_ctrl_t           ctrl;
  logic [MAX_CELLS-1:0] cell_val;
  logic [MAX_CELLS-1:0] cell_moved;
  logic [MAX_CELLS-1:0] cell_act;
  logic [MAX_CELLS-1:0] cell_last;
  logic [MAX_CELLS-1:0] cell_keep;
  logic                 last_val;

  logic             tree_valid;
  logic [CNT_W-1:0] tree_total;
  logic             div_start;
  logic             div_done;
  logic [QUOT_W-1:0] div_quot;

  out_item_t fifo_q [2];
  logic      wp_q, rp_q;
  logic [1:0] fcnt_q;
  logic      push, pop;
  out_item_t push_item;

  assign in_mode = s_axis_tdata[1:0];
  assign in_idx  = s_axis_tdata[IDX_W+1:2];
  assign in_val  = s_axis_tdata[IDX_W+2];

  assign s_axis_tready = (state_q == ST_IDLE) && (fcnt_q != 2'd2);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign load_go       = accept && (in_mode == MODE_LOAD);
  assign step_go       = accept && (in_mode == MODE_STEP);

  assign n_new       = clamp_len(cfg_wdata_i);
  assign ctrl.step   = step_go;
  assign ctrl.cfg_wr = cfg_we_i;

  // The wrap point follows the active length: the last active cell looks
  // ahead to cell zero, and cell zero looks back at the last active cell.
  assign last_val = |(cell_val & cell_last);

  for (genvar i = 0; i < MAX_CELLS; i++) begin : g_cell
    localparam int NXT = (i + 1) % MAX_CELLS;
    logic ahead;
    logic behind;

    assign cell_act[i]  = CNT_W'(i) < n_q;
    assign cell_last[i] = n_q == CNT_W'(i + 1);
    assign cell_keep[i] = CNT_W'(i) < n_new;
    assign ahead        = cell_last[i] ? cell_val[0] : cell_val[NXT];

    if (i == 0) begin : g_first
      assign behind = last_val;
    end else begin : g_rest
      assign behind = cell_val[i-1];
    end

    r184_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (ctrl),
      .act_i    (cell_act[i]),
      .keep_i   (cell_keep[i]),
      .wr_i     (load_go && (in_idx == IDX_W'(i))),
      .wr_val_i (in_val),
      .behind_i (behind),
      .ahead_i  (ahead),
      .val_o    (cell_val[i]),
      .moved_o  (cell_moved[i])
    );
  end

  r184_tree u_tree (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .flush_i     (cfg_we_i),
    .in_valid_i  (go_q),
    .bits_i      ((state_q == ST_RECOUNT) ? cell_val : cell_moved),
    .out_valid_o (tree_valid),
    .total_o     (tree_total)
  );

  assign div_start = (state_q == ST_COUNT) && tree_valid;

  r184_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (tree_total),
    .divisor_i  (tally_q),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  always_comb begin
    tally_d = tally_q;
    if (load_go && cell_act[in_idx] && (cell_val[in_idx] != in_val)) begin
      tally_d = in_val ? (tally_q + 1'b1) : (tally_q - 1'b1);
    end
    if ((state_q == ST_RECOUNT) && tree_valid) begin
      tally_d = tree_total;
    end
  end

  always_comb begin
    state_d = state_q;
    if (cfg_we_i) begin
      state_d = ST_RECOUNT;
    end else begin
      case (state_q)
        ST_IDLE:    if (step_go) state_d = ST_COUNT;
        ST_COUNT:   if (tree_valid) state_d = ST_DIV;
        ST_DIV:     if (div_done) state_d = ST_IDLE;
        ST_RECOUNT: if (tree_valid) state_d = ST_IDLE;
        default:    state_d = ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_RECOUNT;
      n_q     <= CNT_W'(MAX_CELLS);
      tally_q <= '0;
      go_q    <= 1'b1;
    end else begin
      state_q <= state_d;
      tally_q <= tally_d;
      go_q    <= cfg_we_i | step_go;
      if (cfg_we_i) begin
        n_q <= n_new;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (div_start) begin
      moved_q <= tree_total;
    end
  end

  always_comb begin
    push_item                = '0;
    push_item.car_total      = tally_d;
    if (div_done) begin
      push_item.departed_count = moved_q;
      push_item.velocity_q16   = (tally_q == '0) ? '0 : div_quot;
    end else begin
      case (in_mode)
        MODE_READ: push_item.read_value = cell_val[in_idx];
        default:   push_item.read_value = 1'b0;
      endcase
    end
  end

  assign push = (accept && (in_mode != MODE_STEP)) || ((state_q == ST_DIV) && div_done);
  assign pop  = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q   <= 1'b0;
      rp_q   <= 1'b0;
      fcnt_q <= '0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop)  rp_q <= ~rp_q;
      fcnt_q <= fcnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wp_q] <= push_item;
    end
  end

  assign m_axis_tvalid = fcnt_q != '0;
  assign m_axis_tdata  = fifo_q[rp_q];

  a_last_onehot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(cell_last))
    else $error("ring must have exactly one wrap cell");

  a_tally_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (tally_q <= n_q))
    else $error("car tally exceeds active length");

  a_step_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_go && !cfg_we_i) |=> (state_q == ST_COUNT))
    else $error("step request did not start the count");

  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> ((fcnt_q != 2'd2) || pop))
    else $error("result pushed into a full output queue");

endmodule
`default_nettype wire

FILE: rtl/r184_cell.sv
// One road cell: holds a car bit and applies the Rule 184 update.
`timescale 1ns / 1ps
`default_nettype none
module r184_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  r184_pkg::cell_ctrl_t ctrl_i,
  input  logic                act_i,
  input  logic                keep_i,
  input  logic                wr_i,
  input  logic                wr_val_i,
  input  logic                behind_i,
  input  logic                ahead_i,
  output logic                val_o,
  output logic                moved_o
);
  import r184_pkg::*;

  logic val_q;
  logic moved_q;
  logic nxt;

  // A car stays when blocked, and a car behind enters an empty cell.
  assign nxt = act_i & ((val_q & ahead_i) | (behind_i & ~val_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q <= 1'b0;
    end else if (ctrl_i.cfg_wr) begin
      val_q <= val_q & keep_i;
    end else if (ctrl_i.step) begin
      val_q <= nxt;
    end else if (wr_i && act_i) begin
      val_q <= wr_val_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.step) begin
      moved_q <= val_q & ~nxt;
    end
  end

  assign val_o   = val_q;
  assign moved_o = moved_q;

endmodule
`default_nettype wire

FILE: rtl/r184_tree.sv
// Three-stage registered popcount over all ring cells.
`timescale 1ns / 1ps
`default_nettype none
module r184_tree (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         flush_i,
  input  logic                         in_valid_i,
  input  logic [r184_pkg::MAX_CELLS-1:0] bits_i,
  output logic                         out_valid_o,
  output logic [r184_pkg::CNT_W-1:0]   total_o
);
  import r184_pkg::*;

  logic [GRP_W-1:0] grp_q [GRP_CNT];
  logic [SUM_W-1:0] sum_d [SUM_CNT];
  logic [SUM_W-1:0] sum_q [SUM_CNT];
  logic [CNT_W-1:0] total_d;
  logic [CNT_W-1:0] total_q;
  logic [2:0]       vld_q;

  always_ff @(posedge clk_i) begin
    for (int g = 0; g < GRP_CNT; g++) begin
      grp_q[g] <= GRP_W'($countones(bits_i[g*GRP_BITS +: GRP_BITS]));
    end
  end

  always_comb begin
    for (int s = 0; s < SUM_CNT; s++) begin
      sum_d[s] = '0;
      for (int k = 0; k < SUM_FAN; k++) begin
        sum_d[s] = sum_d[s] + SUM_W'(grp_q[s*SUM_FAN + k]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q <= sum_d;
  end

  always_comb begin
    total_d = '0;
    for (int s = 0; s < SUM_CNT; s++) begin
      total_d = total_d + CNT_W'(sum_q[s]);
    end
  end

  always_ff @(posedge clk_i) begin
    total_q <= total_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (flush_i) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[1:0], in_valid_i};
    end
  end

  assign out_valid_o = vld_q[2];
  assign total_o     = total_q;

endmodule
`default_nettype wire

FILE: rtl/r184_div.sv
// Restoring divider giving one quotient bit per cycle for the Q1.16 fraction.
`timescale 1ns / 1ps
`default_nettype none
module r184_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [r184_pkg::CNT_W-1:0]  dividend_i,
  input  logic [r184_pkg::CNT_W-1:0]  divisor_i,
  output logic                        done_o,
  output logic [r184_pkg::QUOT_W-1:0] quot_o
);
  import r184_pkg::*;

  localparam int STEP_W = $clog2(QUOT_W + 1);

  logic              busy_q;
  logic              done_q;
  logic              first_q;
  logic [STEP_W-1:0] cnt_q;
  logic [CNT_W:0]    rem_q;
  logic [CNT_W-1:0]  dvs_q;
  logic [QUOT_W-1:0] quot_q;
  logic [CNT_W:0]    cur;
  logic [CNT_W:0]    rem_d;
  logic              ge;

  // The dividend is the count shifted left by sixteen; the count never exceeds
  // the divisor, so the first step takes it unshifted and gives the integer bit.
  assign cur   = first_q ? rem_q : {rem_q[CNT_W-1:0], 1'b0};
  assign ge    = cur >= {1'b0, dvs_q};
  assign rem_d = ge ? (cur - {1'b0, dvs_q}) : cur;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      first_q <= 1'b0;
      cnt_q   <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q  <= 1'b1;
        first_q <= 1'b1;
        cnt_q   <= STEP_W'(QUOT_W);
      end else if (busy_q) begin
        first_q <= 1'b0;
        cnt_q   <= cnt_q - 1'b1;
        if (cnt_q == STEP_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= {1'b0, dividend_i};
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q  <= rem_d;
      quot_q <= {quot_q[QUOT_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule
`default_nettype wire

FILE: tb/testbench.sv
// Self-checking testbench for the Rule 184 traffic ring: a directed table, then random phases.
`timescale 1ns / 1ps
module testbench;
  import r184_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int RANDOM_REQUESTS = 1600;
  localparam int STALL_LIMIT = 1000;
  localparam int TAIL_CYCLES = 40;

  typedef struct packed {
    logic             is_cfg;
    logic [LEN_W-1:0] road_len;
    logic [1:0]       mode;
    logic [IDX_W-1:0] idx;
    logic             val;
    logic             typed;
    out_item_t        want;
  } plan_row_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [LEN_W-1:0]      cfg_wdata_i;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  rule184_traffic_ring_step_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Shadow copy of the road, the car count and the active ring length.
  bit          road_cells [MAX_CELLS];
  int unsigned shadow_tally = 0;
  int unsigned ring_len = MAX_CELLS;

  out_item_t pending_results [$];
  plan_row_t plan [$];

  int errors = 0;
  int n_items = 0;
  int n_loads = 0;
  int n_steps = 0;
  int n_reads = 0;
  int n_unused = 0;
  int n_results = 0;
  int n_lengths = 0;
  int idle_cycles = 0;
  bit tx_steady = 1'b0;
  bit rx_steady = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic void apply_road_length(logic [LEN_W-1:0] len);
    int unsigned n;
    int unsigned i;
    n = 32'(len);
    if (n < MIN_LEN) n = MIN_LEN;
    if (n > MAX_CELLS) n = MAX_CELLS;
    ring_len = n;
    // Cars beyond the new end of the ring are taken off the road.
    for (i = n; i < MAX_CELLS; i++) begin
      if (road_cells[i]) begin
        road_cells[i] = 1'b0;
        shadow_tally--;
      end
    end
  endfunction

  function automatic int unsigned advance_traffic();
    bit          stepped_road [MAX_CELLS];
    bit          behind;
    bit          here;
    bit          ahead;
    int unsigned moved;
    int unsigned i;
    moved = 0;
    for (i = 0; i < ring_len; i++) begin
      behind = road_cells[(i == 0) ? ring_len - 1 : i - 1];
      here = road_cells[i];
      ahead = road_cells[(i + 1 == ring_len) ? 0 : i + 1];
      stepped_road[i] = (here & ahead) | (behind & ~here);
      if (here && !stepped_road[i]) moved++;
    end
    for (i = 0; i < ring_len; i++) road_cells[i] = stepped_road[i];
    return moved;
  endfunction

  function automatic out_item_t predict_result(logic [1:0] mode, logic [IDX_W-1:0] idx,
                                               logic val);
    out_item_t   r;
    int unsigned moved;
    r = '0;
    case (mode)
      MODE_LOAD: begin
        if (idx < ring_len) begin
          if (!road_cells[idx] && val) shadow_tally++;
          else if (road_cells[idx] && !val) shadow_tally--;
          road_cells[idx] = val;
        end
      end
      MODE_STEP: begin
        moved = advance_traffic();
        r.departed_count = CNT_W'(moved);
        if (shadow_tally != 0) r.velocity_q16 = QUOT_W'((moved << FRAC_BITS) / shadow_tally);
      end
      MODE_READ: begin
        if (idx < ring_len) r.read_value = road_cells[idx];
      end
      default: ;
    endcase
    r.car_total = CNT_W'(shadow_tally);
    return r;
  endfunction

  function automatic void plan_length(logic [LEN_W-1:0] len);
    plan_row_t row;
    row = '0;
    row.is_cfg = 1'b1;
    row.road_len = len;
    plan.push_back(row);
  endfunction

  function automatic void plan_item(logic [1:0] mode, logic [IDX_W-1:0] idx, logic val);
    plan_row_t row;
    row = '0;
    row.mode = mode;
    row.idx = idx;
    row.val = val;
    plan.push_back(row);
  endfunction

  function automatic void plan_checked(logic [1:0] mode, logic [IDX_W-1:0] idx, logic val,
                                       logic rd, int dep, int tot, int vel);
    plan_row_t row;
    row = '0;
    row.mode = mode;
    row.idx = idx;
    row.val = val;
    row.typed = 1'b1;
    row.want.read_value = rd;
    row.want.departed_count = CNT_W'(dep);
    row.want.car_total = CNT_W'(tot);
    row.want.velocity_q16 = QUOT_W'(vel);
    plan.push_back(row);
  endfunction

  task automatic send_request(logic [1:0] mode, logic [IDX_W-1:0] idx, logic val,
                              logic typed, out_item_t want);
    int        gap;
    out_item_t predicted;
    gap = tx_steady ? 0 : $urandom_range(0, 9);
    repeat (gap) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {3'b000, val, idx, mode};
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = predict_result(mode, idx, val);
    pending_results.push_back(typed ? want : predicted);
    n_items++;
    case (mode)
      MODE_LOAD: n_loads++;
      MODE_STEP: n_steps++;
      MODE_READ: n_reads++;
      default:   n_unused++;
    endcase
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_road_length(logic [LEN_W-1:0] len);
    drain_results();
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= len;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    apply_road_length(len);
    n_lengths++;
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  initial begin : result_sink
    int        stall;
    out_item_t got;
    out_item_t want;
    stall = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        n_results++;
        if (pending_results.size() == 0) begin
          $error("result with no request outstanding: %h", got);
          errors++;
        end else begin
          want = pending_results.pop_front();
          check_field("read_value", want.read_value, got.read_value);
          check_field("departed_count", want.departed_count, got.departed_count);
          check_field("car_total", want.car_total, got.car_total);
          check_field("velocity_q16", want.velocity_q16, got.velocity_q16);
        end
        stall = rx_steady ? 0 : $urandom_range(0, 9);
      end
      @(negedge clk_i);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        stall--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Watchdog: no transfer for %0d cycles, %0d results outstanding",
               idle_cycles, pending_results.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    logic [LEN_W-1:0] len;
    logic [1:0]       mode;
    logic [IDX_W-1:0] idx;
    logic             val;
    int               sel;
    int               fill_pct;
    int               phase_items;
    int               n_random;
    int               phase;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    n_random = 0;
    phase = 0;

    // Empty road after reset, the unused mode, and a lone car wrapping past the ring end.
    plan_checked(MODE_READ, 0, 0, 0, 0, 0, 0);
    plan_checked(MODE_STEP, 0, 0, 0, 0, 0, 0);
    plan_checked(MODE_UNUSED, 1023, 1, 0, 0, 0, 0);
    plan_checked(MODE_LOAD, 1023, 1, 0, 0, 1, 0);
    plan_checked(MODE_READ, 1023, 0, 1, 0, 1, 0);
    plan_checked(MODE_STEP, 0, 0, 0, 1, 1, 65536);
    plan_checked(MODE_READ, 0, 0, 1, 0, 1, 0);
    plan_checked(MODE_READ, 1023, 1, 0, 0, 1, 0);
    plan_checked(MODE_LOAD, 0, 0, 0, 0, 0, 0);
    // Two cars nose to tail: only the front one moves.
    plan_item(MODE_LOAD, 1, 1);
    plan_item(MODE_LOAD, 2, 1);
    plan_checked(MODE_STEP, 0, 0, 0, 1, 2, 32768);
    // A length below the minimum saturates to three cells and drops the car at cell 3.
    plan_length(0);
    plan_checked(MODE_READ, 3, 0, 0, 0, 1, 0);
    plan_checked(MODE_LOAD, 5, 1, 0, 0, 1, 0);
    plan_item(MODE_LOAD, 0, 1);
    plan_item(MODE_LOAD, 2, 1);
    plan_checked(MODE_STEP, 0, 0, 0, 0, 3, 0);
    plan_item(MODE_UNUSED, 1023, 1);
    // A length above the maximum saturates to the full road.
    plan_length(2047);
    plan_item(MODE_LOAD, 10'h2AA, 1);
    plan_item(MODE_LOAD, 10'h155, 1);
    plan_item(MODE_READ, 10'h2AA, 0);
    plan_item(MODE_STEP, 0, 0);
    plan_item(MODE_READ, 10'h2AB, 1);

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (plan[r]) begin
      if (plan[r].is_cfg) write_road_length(plan[r].road_len);
      else send_request(plan[r].mode, plan[r].idx, plan[r].val, plan[r].typed, plan[r].want);
    end

    // Random phases: each one sets a ring length while idle, then mixes requests.
    while (n_random < RANDOM_REQUESTS) begin
      case (phase)
        0: len = LEN_W'(3);
        1: len = LEN_W'(1024);
        default: begin
          case ($urandom_range(0, 9))
            0: len = LEN_W'(3);
            1: len = LEN_W'(1024);
            2: len = LEN_W'($urandom_range(0, 2));
            3: len = LEN_W'($urandom_range(1025, 2047));
            4: len = LEN_W'($urandom_range(3, 1024));
            default: len = LEN_W'($urandom_range(3, 40));
          endcase
        end
      endcase
      write_road_length(len);
      tx_steady = ($urandom_range(0, 3) == 0);
      rx_steady = ($urandom_range(0, 3) == 0);
      fill_pct = $urandom_range(10, 90);
      phase_items = $urandom_range(30, 90);
      repeat (phase_items) begin
        sel = $urandom_range(0, 99);
        idx = IDX_W'($urandom);
        val = ($urandom_range(0, 99) < fill_pct);
        if (sel < 5) begin
          mode = MODE_UNUSED;
        end else if (sel < 10) begin
          // Index anywhere in the field, often past the end of a short ring.
          mode = sel[0] ? MODE_LOAD : MODE_READ;
        end else if (sel < 45) begin
          mode = MODE_LOAD;
          idx = IDX_W'($urandom_range(0, ring_len - 1));
        end else if (sel < 75) begin
          mode = MODE_STEP;
        end else begin
          mode = MODE_READ;
          idx = IDX_W'($urandom_range(0, ring_len - 1));
        end
        send_request(mode, idx, val, 1'b0, '0);
        n_random++;
      end
      phase++;
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("Sent %0d requests (%0d loads, %0d steps, %0d reads, %0d unused) across %0d lengths.",
             n_items, n_loads, n_steps, n_reads, n_unused, n_lengths);
    $display("Checked %0d results field by field, %0d mismatches.", n_results, errors);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
